### src/cpbw_pkg.sv
package cpbw_pkg;

   localparam int MAX_CORES      = 16;
   localparam int UTIL_FRAC_BITS = 16;
   localparam int CORE_IDX_W     = $clog2(MAX_CORES);
   localparam int UTIL_W         = UTIL_FRAC_BITS + 1;
   localparam int LOAD_W         = UTIL_FRAC_BITS + 4;
   localparam int CNT_W          = 5;
   localparam int LIMIT_W        = LOAD_W + 4;

   localparam logic [LOAD_W-1:0]  UNIT_LOAD = LOAD_W'(1) << UTIL_FRAC_BITS;
   localparam logic [LOAD_W-1:0]  LOAD_MAX  = {LOAD_W{1'b1}};
   // worst fit cutoff: load * 10 < 1.1 * 10
   localparam logic [LIMIT_W-1:0] WF_LIMIT  = LIMIT_W'(UNIT_LOAD) * LIMIT_W'(11);

   localparam logic REG_CORE_COUNT = 1'b0;
   localparam logic REG_FIT_MODE   = 1'b1;

   localparam logic MODE_BEST  = 1'b0;
   localparam logic MODE_WORST = 1'b1;

   // search token walking along the cell chain
   typedef struct packed {
      logic                  valid;
      logic                  found;
      logic [CORE_IDX_W-1:0] idx;
      logic [LOAD_W-1:0]     key;
   } tok_type;

   // load update broadcast to all cells
   typedef struct packed {
      logic                  clear;
      logic                  add;
      logic [CORE_IDX_W-1:0] idx;
   } upd_type;

endpackage

### src/cpbw_cell.sv
module cpbw_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [cpbw_pkg::CORE_IDX_W-1:0] cell_idx,
   input  logic [cpbw_pkg::CNT_W-1:0]      core_count,
   input  logic                            fit_mode,
   input  logic [cpbw_pkg::UTIL_W-1:0]     util,
   input  cpbw_pkg::upd_type               upd,
   input  cpbw_pkg::tok_type               tok_i,
   output cpbw_pkg::tok_type               tok_o
);

   logic [cpbw_pkg::LOAD_W-1:0]  load_ff, load_in;
   cpbw_pkg::tok_type            tok_ff, tok_in;
   logic [cpbw_pkg::LOAD_W-1:0]  remain;
   logic [cpbw_pkg::LOAD_W-1:0]  key;
   logic [cpbw_pkg::LIMIT_W-1:0] load_x10;
   logic [cpbw_pkg::LOAD_W:0]    sum;
   logic                         elig, best_ok, worst_ok, ok, take;

   always_comb begin
      remain   = cpbw_pkg::UNIT_LOAD - load_ff;
      best_ok  = (load_ff < cpbw_pkg::UNIT_LOAD) &&
                 (remain > cpbw_pkg::LOAD_W'(util));
      load_x10 = cpbw_pkg::LIMIT_W'(load_ff) * cpbw_pkg::LIMIT_W'(10);
      worst_ok = load_x10 < cpbw_pkg::WF_LIMIT;
      elig     = cpbw_pkg::CNT_W'(cell_idx) < core_count;
      ok       = (fit_mode == cpbw_pkg::MODE_WORST) ? worst_ok : best_ok;
      key      = (fit_mode == cpbw_pkg::MODE_WORST) ? load_ff : remain;
      take     = tok_i.valid && elig && ok && (!tok_i.found || key < tok_i.key);

      tok_in = tok_i;
      if (take) begin
         tok_in.found = 1'b1;
         tok_in.idx   = cell_idx;
         tok_in.key   = key;
      end

      sum     = {1'b0, load_ff} + (cpbw_pkg::LOAD_W + 1)'(util);
      load_in = load_ff;
      if (upd.clear) begin
         load_in = '0;
      end else if (upd.add && upd.idx == cell_idx) begin
         load_in = sum[cpbw_pkg::LOAD_W] ? cpbw_pkg::LOAD_MAX : sum[cpbw_pkg::LOAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
         tok_ff  <= '0;
      end else begin
         load_ff <= load_in;
         tok_ff  <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

### src/core_partition_best_worst_fit.sv
// Channel   Direction  Handshake            Payload
// req       in         req_tvalid/tready    tdata: task_utilization; tuser: new_set
// rsp       out        rsp_tvalid/tready    tdata: assigned_core;    tuser: placed
// csr       in         csr_we               csr_addr, csr_wdata (core_count, fit_mode)
//
// Each task is accepted, launches the search token, lets it walk the MAX_CORES cells
// of the chain and posts the result; no new task is taken until the last is through.
// A task after a sticky failure, unless it starts a new set, skips the walk.
// Synchronous active-high reset clears all core loads and the failure flag, and sets config to one core, best fit.
// req_tready is high only while idle; a result waiting on rsp holds the next one
// in the done state until the output register frees.
module core_partition_best_worst_fit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [23:0]                  req_tdata,   // [16:0] task_utilization
   input  logic                         req_tuser,   // [0] new_set
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [3:0] assigned_core
   output logic                         rsp_tuser,   // [0] placed
   input  logic                         csr_we,
   input  logic                         csr_addr,
   input  logic [cpbw_pkg::CNT_W-1:0]   csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_LAUNCH, ST_WAIT, ST_DONE} state_type;

   state_type                        state_ff, state_in;
   logic [cpbw_pkg::CNT_W-1:0]       core_count_ff;
   logic                             fit_mode_ff;
   logic [cpbw_pkg::UTIL_W-1:0]      util_ff, util_in;
   logic                             failed_ff, failed_in;
   logic [cpbw_pkg::CORE_IDX_W-1:0]  res_core_ff, res_core_in;
   logic                             res_placed_ff, res_placed_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [cpbw_pkg::CORE_IDX_W-1:0]  rsp_core_ff, rsp_core_in;
   logic                             rsp_placed_ff, rsp_placed_in;
   logic                             req_acc;
   cpbw_pkg::upd_type                upd;
   cpbw_pkg::tok_type                tok_chain [cpbw_pkg::MAX_CORES+1];
   logic [cpbw_pkg::MAX_CORES-1:0]   tok_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         core_count_ff <= cpbw_pkg::CNT_W'(1);
         fit_mode_ff   <= cpbw_pkg::MODE_BEST;
      end else if (csr_we) begin
         unique case (csr_addr)
            cpbw_pkg::REG_CORE_COUNT: core_count_ff <= csr_wdata;
            cpbw_pkg::REG_FIT_MODE:   fit_mode_ff   <= csr_wdata[0];
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      tok_chain[0]       = '0;
      tok_chain[0].valid = (state_ff == ST_LAUNCH);
   end

   for (genvar g = 0; g < cpbw_pkg::MAX_CORES; g++) begin : g_cell
      cpbw_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (cpbw_pkg::CORE_IDX_W'(g)),
         .core_count (core_count_ff),
         .fit_mode   (fit_mode_ff),
         .util       (util_ff),
         .upd        (upd),
         .tok_i      (tok_chain[g]),
         .tok_o      (tok_chain[g+1])
      );
      assign tok_busy[g] = tok_chain[g+1].valid;
   end

   always_comb begin
      state_in      = state_ff;
      util_in       = util_ff;
      failed_in     = failed_ff;
      res_core_in   = res_core_ff;
      res_placed_in = res_placed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_core_in   = rsp_core_ff;
      rsp_placed_in = rsp_placed_ff;
      upd           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               util_in   = req_tdata[cpbw_pkg::UTIL_W-1:0];
               upd.clear = req_tuser;
               if (req_tuser) begin
                  failed_in = 1'b0;
               end
               if (req_tuser || !failed_ff) begin
                  state_in = ST_LAUNCH;
               end else begin
                  res_core_in   = '0;
                  res_placed_in = 1'b0;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_LAUNCH: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (tok_chain[cpbw_pkg::MAX_CORES].valid) begin
               upd.add       = tok_chain[cpbw_pkg::MAX_CORES].found;
               upd.idx       = tok_chain[cpbw_pkg::MAX_CORES].idx;
               failed_in     = !tok_chain[cpbw_pkg::MAX_CORES].found;
               res_placed_in = tok_chain[cpbw_pkg::MAX_CORES].found;
               res_core_in   = tok_chain[cpbw_pkg::MAX_CORES].found ?
                               tok_chain[cpbw_pkg::MAX_CORES].idx : '0;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_core_in   = res_core_ff;
               rsp_placed_in = res_placed_ff;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      util_ff       <= util_in;
      res_core_ff   <= res_core_in;
      res_placed_ff <= res_placed_in;
      rsp_core_ff   <= rsp_core_in;
      rsp_placed_ff <= rsp_placed_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 8'(rsp_core_ff);
   assign rsp_tuser  = rsp_placed_ff;

`ifndef ASSERT_OFF
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_busy))
      else $error("more than one search token in the cell chain");

   a_idle_chain: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> (tok_busy == '0))
      else $error("transaction accepted while a search is in flight");

   a_no_launch_failed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAUNCH) |-> !failed_ff)
      else $error("search launched after a sticky failure");

   a_unplaced_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !res_placed_ff) |-> (res_core_ff == '0))
      else $error("unplaced result carries a nonzero core");
`endif

endmodule
